### rtl/smnmm_pkg.sv
// ----------------------------------------------------------------------------
// smnmm_pkg: shared types and constants
// Sequencer states and fixed field widths of the min/max normaliser.
// ----------------------------------------------------------------------------
package smnmm_pkg;

	localparam int unsigned SAMPLE_PORT_BITS = 12;
	localparam int unsigned LEVEL_BITS       = 10;
	localparam int unsigned MEAN_BITS        = 12;
	localparam int unsigned FULL_SCALE       = 1000;
	localparam int unsigned SCALE_BITS       = 10;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV_LVL,
		S_FIN
	} smnmm_state_t;

endpackage

### rtl/smnmm_div.sv
// ----------------------------------------------------------------------------
// smnmm_div: restoring divider
// One quotient bit per cycle; a start request reloads it at any time.
// ----------------------------------------------------------------------------
module smnmm_div #(
	parameter int unsigned NUM_BITS = 22,
	parameter int unsigned DEN_BITS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                done,
	output logic [NUM_BITS-1:0] quotient
);

	localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;

	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   trial;
	logic                fits;

	assign shifted = {rem_q, quo_q[NUM_BITS-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(NUM_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_BITS'(1);
			done_q <= (cnt_q == CNT_BITS'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so the top bit is always dropped
			rem_q <= fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/smnmm_ring.sv
// ----------------------------------------------------------------------------
// smnmm_ring: sample ring memory
// Single write port, registered read; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module smnmm_ring #(
	parameter int unsigned DEPTH     = 100,
	parameter int unsigned DATA_BITS = 12,
	parameter int unsigned ADDR_BITS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [DATA_BITS-1:0] rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

### rtl/sample_minmax_normalize_moving_mean_core.sv
// ----------------------------------------------------------------------------
// sample_minmax_normalize_moving_mean_core: min/max normaliser with moving mean
// Tracks the sample range, scales each sample to 0..1000 and reports the
// truncated mean of the last WINDOW samples.
// ----------------------------------------------------------------------------
// Use:
//   Input channel in_valid/in_ready carries one request: a 12-bit sample.
//   Output channel out_valid/out_ready returns norm_level and window_mean for
//   every request, in order. Both use plain valid/ready handshakes.
// Timing:
//   One restoring divider forms the level, one quotient bit a cycle
//   over NUM_BITS = SAMPLE_BITS + 10 bits. The mean is the running sum times
//   a constant reciprocal of WINDOW, taken as the result is loaded. A request
//   passes S_PREP, then S_DIV_LVL while the divider runs, then S_FIN, where
//   the result is loaded; an edge-case level skips S_DIV_LVL and no division
//   runs. in_ready is high only while the sequencer is idle, so one request
//   is in flight at a time.
// Stall:
//   A finished result waits in the output register; the next request is
//   still taken. If the receiver has not taken the old result by the time
//   the next one is ready, the sequencer holds in its final state.
// Reset:
//   arst_n clears the range (max 0, min all ones), the running sum, the ring
//   position and every ring entry's valid bit, so the ring reads as zeros.
//   No clearing pass is needed; the block is ready straight after reset.
// ----------------------------------------------------------------------------
module sample_minmax_normalize_moving_mean_core #(
	parameter int unsigned WINDOW      = 100,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [smnmm_pkg::SAMPLE_PORT_BITS-1:0] sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [smnmm_pkg::LEVEL_BITS-1:0]       norm_level,
	output logic [smnmm_pkg::MEAN_BITS-1:0]        window_mean
);

	import smnmm_pkg::*;

	// ring address, running sum, divider widths
	localparam int unsigned ADDR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned TOT_BITS  = SAMPLE_BITS + 8;
	localparam int unsigned NUM_BITS  = SAMPLE_BITS + SCALE_BITS;
	localparam int unsigned DEN_BITS  = SAMPLE_BITS + 1;

	// reciprocal of WINDOW, rounded up: exact for every sum below 2^TOT_BITS
	localparam int unsigned MEAN_SHIFT = TOT_BITS + $clog2(WINDOW);
	localparam int unsigned MUL_BITS   = TOT_BITS + 1;
	localparam int unsigned PROD_BITS  = TOT_BITS + MUL_BITS;
	localparam logic [MUL_BITS-1:0] MEAN_RECIP =
		MUL_BITS'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	smnmm_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] smp_q;
	logic [SAMPLE_BITS-1:0] high_q;
	logic [SAMPLE_BITS-1:0] low_q;
	logic [TOT_BITS-1:0]    total_q;
	logic [ADDR_BITS-1:0]   slot_q;
	logic [LEVEL_BITS-1:0]  level_q;
	logic [LEVEL_BITS-1:0]  norm_q;
	logic [MEAN_BITS-1:0]   mean_q;
	logic                   out_valid_q;

	logic [SAMPLE_BITS-1:0] smp_in;
	logic                   accept;
	logic                   out_load;
	logic                   lvl_zero;
	logic                   lvl_full;
	logic                   div_start;
	logic                   ring_wr;
	logic [SAMPLE_BITS-1:0] old_smp;
	logic [TOT_BITS-1:0]    total_next;
	logic [NUM_BITS-1:0]    lvl_num;
	logic [DEN_BITS-1:0]    div_den;
	logic                   div_done;
	logic [NUM_BITS-1:0]    div_quo;
	logic [PROD_BITS-1:0]   mean_prod;
	logic [MEAN_BITS-1:0]   mean_calc;

	// keep only the low SAMPLE_BITS of the port (zero-extend when wider)
	assign smp_in = SAMPLE_BITS'(sample);
	assign accept = in_valid && in_ready;

	// edge cases of the scaled level, judged on the already widened range
	assign lvl_zero = (high_q <= low_q) || (smp_q <= low_q);
	assign lvl_full = smp_q >= high_q;

	assign total_next = total_q - TOT_BITS'(old_smp) + TOT_BITS'(smp_q);
	assign lvl_num    = NUM_BITS'(smp_q - low_q) * NUM_BITS'(FULL_SCALE);
	assign div_den    = DEN_BITS'(high_q - low_q);

	// mean of the settled running sum, read only when the result is loaded
	assign mean_prod = PROD_BITS'(total_q) * PROD_BITS'(MEAN_RECIP);
	assign mean_calc = MEAN_BITS'(mean_prod >> MEAN_SHIFT);

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		ring_wr   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = S_PREP;
			end
			S_PREP: begin
				// ring read data is here: update sum, write ring, divide if needed
				ring_wr = 1'b1;
				if (lvl_zero || lvl_full) begin
					state_d = S_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV_LVL;
				end
			end
			S_DIV_LVL: begin
				if (div_done)
					state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// control-side state: range, sum, ring position, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q      <= '0;
			low_q       <= '1;
			total_q     <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (smp_in > high_q)
					high_q <= smp_in;
				if (smp_in < low_q)
					low_q <= smp_in;
			end
			if (ring_wr) begin
				total_q <= total_next;
				slot_q  <= (slot_q == ADDR_BITS'(WINDOW - 1)) ? '0
				                                             : slot_q + ADDR_BITS'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept)
			smp_q <= smp_in;
		if (state_q == S_PREP)
			level_q <= lvl_zero ? '0 : LEVEL_BITS'(FULL_SCALE);
		else if (state_q == S_DIV_LVL && div_done)
			level_q <= div_quo[LEVEL_BITS-1:0];
		if (out_load) begin
			norm_q <= level_q;
			mean_q <= mean_calc;
		end
	end

	smnmm_ring #(
		.DEPTH     (WINDOW),
		.DATA_BITS (SAMPLE_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (slot_q),
		.rd_data (old_smp),
		.wr_en   (ring_wr),
		.wr_addr (slot_q),
		.wr_data (smp_q)
	);

	smnmm_div #(
		.NUM_BITS (NUM_BITS),
		.DEN_BITS (DEN_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lvl_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid   = out_valid_q;
	assign norm_level  = norm_q;
	assign window_mean = mean_q;

	// a delivered level never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (norm_level <= LEVEL_BITS'(FULL_SCALE)))
		else $error("norm_level above full scale");

	// once a sample has been taken the tracked range is never inverted
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (high_q >= low_q))
		else $error("tracked max below tracked min");

	// the ring position always stays inside the window
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= ADDR_BITS'(WINDOW - 1))
		else $error("ring position outside window");

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_LVL))
		else $error("divider finished outside the division state");

endmodule

### sim/tb_sample_minmax_normalize_moving_mean_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_minmax_normalize_moving_mean_core: normaliser and moving mean check
// Feeds converter samples through a valid/ready driver, predicts the scaled
// level and the ring mean of every request, and compares each returned result
// in order. Both sides idle at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
module tb_sample_minmax_normalize_moving_mean_core;

	import smnmm_pkg::*;

	localparam int unsigned RING_DEPTH    = 100;
	localparam int unsigned ADC_BITS      = 12;
	localparam int unsigned SAMPLE_TARGET = 1750;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned MISMATCH_SHOW = 10;
	localparam int unsigned IDLE_PERCENT  = 34;
	localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

	typedef logic [SAMPLE_PORT_BITS-1:0] sample_t;

	// One queued request; the flag makes the driver wait for an empty pipe first.
	typedef struct {
		sample_t smp;
		bit      hold_for_drain;
	} sample_req_t;

	typedef struct {
		logic [LEVEL_BITS-1:0] level;
		logic [MEAN_BITS-1:0]  mean;
	} level_mean_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	sample_t                     sample = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [LEVEL_BITS-1:0]       norm_level;
	logic [MEAN_BITS-1:0]        window_mean;

	sample_req_t                 sample_backlog[$];
	level_mean_t                 level_mean_q[$];

	// Shadow of the block's state, advanced once per accepted request
	logic [ADC_BITS-1:0]         track_max;
	logic [ADC_BITS-1:0]         track_min;
	logic [ADC_BITS-1:0]         ring_store[RING_DEPTH];
	int unsigned                 ring_slot;
	int unsigned                 ring_total;

	int                          outstanding = 0;
	int unsigned                 requests_taken = 0;
	int unsigned                 mismatches = 0;
	int unsigned                 stall_cycles = 0;
	logic                        calm;

	sample_minmax_normalize_moving_mean_core #(
		.WINDOW      (RING_DEPTH),
		.SAMPLE_BITS (ADC_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.norm_level  (norm_level),
		.window_mean (window_mean)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// No idling on either side while this window of requests goes through
	assign calm = (requests_taken >= 700) && (requests_taken < 1000);

	// Widen the range, scale the sample against it, then roll the ring and
	// report the truncated mean of every entry.
	function automatic level_mean_t normalise_and_average(sample_t raw);
		level_mean_t         r;
		logic [ADC_BITS-1:0] s;
		int unsigned         lvl;
		s = raw[ADC_BITS-1:0];
		if (s > track_max)
			track_max = s;
		if (s < track_min)
			track_min = s;
		if (track_max <= track_min || s <= track_min)
			lvl = 0;
		else if (s >= track_max)
			lvl = FULL_SCALE;
		else
			lvl = ((int'(s) - int'(track_min)) * FULL_SCALE) /
				(int'(track_max) - int'(track_min));
		ring_total = ring_total - ring_store[ring_slot] + s;
		ring_store[ring_slot] = s;
		ring_slot = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
		r.level = lvl[LEVEL_BITS-1:0];
		r.mean  = MEAN_BITS'(ring_total / RING_DEPTH);
		return r;
	endfunction

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= MISMATCH_SHOW)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic void queue_sample(sample_t v, bit drain);
		sample_req_t req;
		req.smp            = v;
		req.hold_for_drain = drain;
		sample_backlog.push_back(req);
	endfunction

	// Driver: present the next request once the last one has gone, with random
	// gaps. A request flagged for draining waits until no result is pending.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
		end else if (!in_valid || in_ready) begin
			if (sample_backlog.size() != 0 &&
			    (calm || $urandom_range(99) >= IDLE_PERCENT) &&
			    (!sample_backlog[0].hold_for_drain || (!in_valid && outstanding == 0))) begin
				in_valid <= 1'b1;
				sample   <= sample_backlog[0].smp;
				void'(sample_backlog.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stall the receiver at random, check each returned result against
	// the oldest prediction, then predict for a request taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		level_mean_t want;
		if (!arst_n) begin
			out_ready      <= 1'b0;
			outstanding    <= 0;
			requests_taken <= 0;
			track_max      = '0;
			track_min      = ADC_MAX;
			ring_slot      = 0;
			ring_total     = 0;
			for (int i = 0; i < RING_DEPTH; i++)
				ring_store[i] = '0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
			if (out_valid && out_ready) begin
				if (level_mean_q.size() == 0) begin
					flag_mismatch($sformatf("result with nothing pending: level %0d mean %0d",
						norm_level, window_mean));
				end else begin
					want = level_mean_q.pop_front();
					if (norm_level !== want.level)
						flag_mismatch($sformatf("norm_level expected %0d got %0d",
							want.level, norm_level));
					if (window_mean !== want.mean)
						flag_mismatch($sformatf("window_mean expected %0d got %0d",
							want.mean, window_mean));
				end
			end
			if (in_valid && in_ready) begin
				level_mean_q.push_back(normalise_and_average(sample));
				requests_taken <= requests_taken + 1;
			end
			outstanding <= outstanding + int'(in_valid && in_ready) - int'(out_valid && out_ready);
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("sample_minmax_normalize_moving_mean_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned kind;
		int unsigned run_len;
		sample_t     v;

		// Directed: a narrow range first, since the range can only widen
		queue_sample(12'd2000, 1'b0);   // single point: empty range gives 0
		queue_sample(12'd2000, 1'b0);   // repeat of the only value
		queue_sample(12'd2100, 1'b0);   // new maximum: full scale
		queue_sample(12'd2050, 1'b0);   // middle of the range
		queue_sample(12'd2000, 1'b0);   // exactly at the minimum
		queue_sample(12'd1900, 1'b0);   // new minimum
		queue_sample(12'd2100, 1'b0);   // exactly at the maximum
		queue_sample(12'd2099, 1'b0);   // one below the maximum
		queue_sample(12'd1901, 1'b0);   // one above the minimum: smallest non-zero
		queue_sample(12'd1999, 1'b0);
		queue_sample(12'd0, 1'b0);      // lowest code
		queue_sample(12'd4095, 1'b0);   // highest code
		queue_sample(12'd1, 1'b0);
		queue_sample(12'd4094, 1'b0);
		queue_sample(12'd2047, 1'b0);
		queue_sample(12'd2048, 1'b0);
		queue_sample(12'hAAA, 1'b0);
		queue_sample(12'h555, 1'b0);
		queue_sample(12'd4095, 1'b0);
		queue_sample(12'd0, 1'b0);
		queue_sample(12'd5, 1'b0);      // truncation just above zero
		queue_sample(12'd4091, 1'b0);   // truncation just below full scale

		// Random: single samples and runs of varied content, with long runs that fill the
		// ring and walk the write position through its wrap many times
		while (sample_backlog.size() < SAMPLE_TARGET) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				queue_sample(sample_t'($urandom_range(4095)),
					sample_backlog.size() == 22 || $urandom_range(199) == 0);
			end else if (kind < 62) begin
				v       = sample_t'($urandom_range(4095));
				run_len = $urandom_range(20, 2);
				for (int i = 0; i < run_len; i++)
					queue_sample(v, 1'b0);
			end else if (kind < 65) begin
				// Saturate the ring: mean reaches a code extreme
				v       = $urandom_range(1) ? ADC_MAX : '0;
				run_len = $urandom_range(120, 100);
				for (int i = 0; i < run_len; i++)
					queue_sample(v, 1'b0);
			end else if (kind < 80) begin
				case ($urandom_range(5))
					0: v = 12'd0;
					1: v = 12'd1;
					2: v = 12'd2047;
					3: v = 12'd2048;
					4: v = 12'd4094;
					default: v = 12'd4095;
				endcase
				queue_sample(v, 1'b0);
			end else begin
				// Drift around a centre so neighbouring levels differ by little
				v       = sample_t'($urandom_range(4000, 95));
				run_len = $urandom_range(16, 4);
				for (int i = 0; i < run_len; i++)
					queue_sample(sample_t'(int'(v) + $urandom_range(94) - 47), 1'b0);
			end
		end

		// Hold reset, then release it once
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (sample_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && level_mean_q.size() == 0)
			$display("sample_minmax_normalize_moving_mean_core verification clean");
		else
			$display("sample_minmax_normalize_moving_mean_core verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/smnmm_pkg.sv
rtl/smnmm_div.sv
rtl/smnmm_ring.sv
rtl/sample_minmax_normalize_moving_mean_core.sv
sim/tb_sample_minmax_normalize_moving_mean_core.sv
